@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while reset is held
`define BPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every rising edge, reset included
`define BPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/bpc_pkg.sv @@
// shared types and constants of the pressure compensation block
// no dependencies
`timescale 1ns / 1ps

package bpc_pkg;

    // calibration words as held in the register bank
    typedef struct packed {
        logic [15:0] sens_coeff;         // c1
        logic [15:0] offset_coeff;       // c2
        logic [15:0] sens_temp_coeff;    // c3
        logic [15:0] offset_temp_coeff;  // c4
        logic [15:0] ref_temp_coeff;     // c5
        logic [15:0] temp_slope_coeff;   // c6
    } t_cal;

    // register index = paddr / 4
    typedef enum logic [2:0] {
        REG_SENS       = 3'd0,
        REG_OFFSET     = 3'd1,
        REG_SENS_TEMP  = 3'd2,
        REG_OFFSET_TMP = 3'd3,
        REG_REF_TEMP   = 3'd4,
        REG_TEMP_SLOPE = 3'd5
    } t_reg_idx;

    localparam int PIPE_STAGES = 9;

    localparam int TEMP_REF = 2000;   // second-order threshold, 20.00 degC
    localparam int TEMP_LOW = -1500;  // extra-term threshold, -15.00 degC
    localparam int TEMP_MIN = -4000;
    localparam int TEMP_MAX = 8500;
    localparam int PRES_MIN = 1000;
    localparam int PRES_MAX = 120000;

endpackage

@@ rtl/core/bpc_pipe.sv @@
// nine-stage compensation datapath with per-stage valid and ready
// depends on bpc_pkg (t_cal, range and threshold constants)
`timescale 1ns / 1ps

module bpc_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bpc_pkg::t_cal      i_cal,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [23:0]        i_raw_pressure,
    input  logic [23:0]        i_raw_temperature,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [14:0] o_temperature,
    output logic [16:0]        o_pressure
);

    localparam int NSTG = bpc_pkg::PIPE_STAGES;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_en;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        stg_en[NSTG-1] = ~r_vld[NSTG-1] | i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = ~r_vld[k] | stg_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_ready  = stg_en[0];
    assign o_out_valid = r_vld[NSTG-1];

    // stage 1: dT
    logic [23:0]        r1_d1;
    logic signed [24:0] r1_dt;

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r1_d1 <= i_raw_pressure;
            r1_dt <= $signed({1'b0, i_raw_temperature})
                   - $signed({1'b0, i_cal.ref_temp_coeff, 8'h00});
        end
    end

    // stage 2: the four products of dT
    logic [23:0]        r2_d1;
    logic signed [41:0] r2_p6;
    logic signed [41:0] r2_p4;
    logic signed [41:0] r2_p3;
    logic signed [49:0] r2_pdd;

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r2_d1  <= r1_d1;
            r2_p6  <= r1_dt * $signed({1'b0, i_cal.temp_slope_coeff});
            r2_p4  <= r1_dt * $signed({1'b0, i_cal.offset_temp_coeff});
            r2_p3  <= r1_dt * $signed({1'b0, i_cal.sens_temp_coeff});
            r2_pdd <= r1_dt * r1_dt;
        end
    end

    // stage 3: first-order terms; r3_a is TEMP - 2000
    logic [23:0]        r3_d1;
    logic signed [18:0] r3_a;
    logic signed [41:0] r3_off;
    logic signed [41:0] r3_sens;
    logic [16:0]        r3_t2;

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r3_d1   <= r2_d1;
            r3_a    <= r2_p6[41:23];
            r3_off  <= $signed({9'h000, i_cal.offset_coeff, 17'h00000}) + (r2_p4 >>> 6);
            r3_sens <= $signed({10'h000, i_cal.sens_coeff, 16'h0000}) + (r2_p3 >>> 7);
            r3_t2   <= r2_pdd[47:31];
        end
    end

    // stage 4: squares, thresholds, final temperature
    logic               s4_lt_ref;
    logic               s4_lt_low;
    logic signed [19:0] s4_b;
    logic [16:0]        s4_t2;
    logic signed [20:0] s4_temp;
    logic signed [14:0] s4_temp_sat;
    logic signed [37:0] s4_aa;
    logic signed [39:0] s4_bb;

    always_comb begin
        s4_lt_ref = r3_a[18];
        s4_lt_low = r3_a < $signed(19'(bpc_pkg::TEMP_LOW - bpc_pkg::TEMP_REF));
        s4_b      = $signed({r3_a[18], r3_a})
                  + $signed(20'(bpc_pkg::TEMP_REF - bpc_pkg::TEMP_LOW));
        s4_t2     = s4_lt_ref ? r3_t2 : '0;
        s4_temp   = $signed({{2{r3_a[18]}}, r3_a}) + $signed(21'(bpc_pkg::TEMP_REF))
                  - $signed({4'h0, s4_t2});
        if (s4_temp < $signed(21'(bpc_pkg::TEMP_MIN))) begin
            s4_temp_sat = 15'(bpc_pkg::TEMP_MIN);
        end else if (s4_temp > $signed(21'(bpc_pkg::TEMP_MAX))) begin
            s4_temp_sat = 15'(bpc_pkg::TEMP_MAX);
        end else begin
            s4_temp_sat = s4_temp[14:0];
        end
        s4_aa = r3_a * r3_a;
        s4_bb = s4_b * s4_b;
    end

    logic [23:0]        r4_d1;
    logic signed [41:0] r4_off;
    logic signed [41:0] r4_sens;
    logic signed [14:0] r4_temp;
    logic               r4_lt_ref;
    logic               r4_lt_low;
    logic [36:0]        r4_aa;
    logic [36:0]        r4_bb;

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r4_d1     <= r3_d1;
            r4_off    <= r3_off;
            r4_sens   <= r3_sens;
            r4_temp   <= s4_temp_sat;
            r4_lt_ref <= s4_lt_ref;
            r4_lt_low <= s4_lt_low;
            r4_aa     <= s4_aa[36:0];
            r4_bb     <= s4_bb[36:0];
        end
    end

    // stage 5: second-order offset and sensitivity, shift-and-add constants
    logic [42:0] s5_aa61;
    logic [40:0] s5_bb15;
    logic [41:0] s5_off2;
    logic [41:0] s5_sens2;

    always_comb begin
        s5_aa61 = {r4_aa, 6'h00} - {4'h0, r4_aa, 2'h0} + {6'h00, r4_aa};
        s5_bb15 = {r4_bb, 4'h0} - {4'h0, r4_bb};
        s5_off2  = '0;
        s5_sens2 = '0;
        if (r4_lt_ref) begin
            s5_off2  = {3'h0, s5_aa61[42:4]};
            s5_sens2 = {4'h0, r4_aa, 1'b0};
            if (r4_lt_low) begin
                s5_off2  = s5_off2 + {1'b0, s5_bb15};
                s5_sens2 = s5_sens2 + {2'h0, r4_bb, 3'h0};
            end
        end
    end

    logic [23:0]        r5_d1;
    logic signed [41:0] r5_off;
    logic signed [41:0] r5_sens;
    logic signed [14:0] r5_temp;
    logic [41:0]        r5_off2;
    logic [41:0]        r5_sens2;

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r5_d1    <= r4_d1;
            r5_off   <= r4_off;
            r5_sens  <= r4_sens;
            r5_temp  <= r4_temp;
            r5_off2  <= s5_off2;
            r5_sens2 <= s5_sens2;
        end
    end

    // stage 6: corrected offset and sensitivity
    logic [23:0]        r6_d1;
    logic signed [41:0] r6_off;
    logic signed [41:0] r6_sens;
    logic signed [14:0] r6_temp;

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r6_d1   <= r5_d1;
            r6_off  <= r5_off - $signed(r5_off2);
            r6_sens <= r5_sens - $signed(r5_sens2);
            r6_temp <= r5_temp;
        end
    end

    // stage 7: D1 * SENS as two partial products, sens split at bit 21
    logic [44:0]        r7_pl;
    logic signed [45:0] r7_ph;
    logic signed [41:0] r7_off;
    logic signed [14:0] r7_temp;

    always_ff @(posedge i_clk) begin
        if (stg_en[6]) begin
            r7_pl   <= r6_d1 * r6_sens[20:0];
            r7_ph   <= $signed({1'b0, r6_d1}) * $signed(r6_sens[41:21]);
            r7_off  <= r6_off;
            r7_temp <= r6_temp;
        end
    end

    // stage 8: (D1*SENS >> 21) - OFF; the high part already carries the 2^21
    logic signed [47:0] r8_diff;
    logic signed [14:0] r8_temp;

    always_ff @(posedge i_clk) begin
        if (stg_en[7]) begin
            r8_diff <= $signed({r7_ph[45], r7_ph[45], r7_ph})
                     + $signed({24'h000000, r7_pl[44:21]})
                     - $signed({{6{r7_off[41]}}, r7_off});
            r8_temp <= r7_temp;
        end
    end

    // stage 9: >> 15 and saturation, output register
    logic signed [32:0] s9_p;
    logic [16:0]        s9_p_sat;

    always_comb begin
        s9_p = r8_diff[47:15];
        if (s9_p < $signed(33'(bpc_pkg::PRES_MIN))) begin
            s9_p_sat = 17'(bpc_pkg::PRES_MIN);
        end else if (s9_p > $signed(33'(bpc_pkg::PRES_MAX))) begin
            s9_p_sat = 17'(bpc_pkg::PRES_MAX);
        end else begin
            s9_p_sat = s9_p[16:0];
        end
    end

    logic signed [14:0] r9_temp;
    logic [16:0]        r9_pres;

    always_ff @(posedge i_clk) begin
        if (stg_en[8]) begin
            r9_temp <= r8_temp;
            r9_pres <= s9_p_sat;
        end
    end

    assign o_temperature = r9_temp;
    assign o_pressure    = r9_pres;

endmodule

@@ rtl/core/baro_pressure_compensation.sv @@
// barometric sensor compensation: register bank and stream wrapper
// depends on bpc_pkg and bpc_pipe
`timescale 1ns / 1ps

// Usage
//   slave stream: one raw conversion pair per item, D1 in the low 24 bits
//   and D2 in the next 24 bits of the input tdata.
//   master stream: one compensated item per input item, in input order;
//   temperature in 0.01 degC (signed, clamped to -4000..8500) and pressure
//   in 0.01 mbar (clamped to 1000..120000).
//   apb port: six 16-bit calibration words c1..c6 at byte addresses 0..20;
//   write them while no item is in flight. unused addresses read zero and
//   ignore writes. pready is tied high.
// Timing
//   nine register stages, from dT to the output register. one item per
//   cycle is sustained while tready is high, set by the fully pipelined
//   datapath (every multiplier has a stage).
// Reset and stall
//   synchronous active-low reset empties the pipeline and clears the
//   calibration words to zero. when the receiver holds tready low, each
//   stage still fills up until it holds an item, so inputs keep being taken
//   into empty stages; once all stages are full the slave tready drops.

module baro_pressure_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // temperature[14:0], pressure[31:15]
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bpc_pkg::t_cal r_cal;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    // register writes, decoded on the word index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                bpc_pkg::REG_SENS:       r_cal.sens_coeff        <= pwdata[15:0];
                bpc_pkg::REG_OFFSET:     r_cal.offset_coeff      <= pwdata[15:0];
                bpc_pkg::REG_SENS_TEMP:  r_cal.sens_temp_coeff   <= pwdata[15:0];
                bpc_pkg::REG_OFFSET_TMP: r_cal.offset_temp_coeff <= pwdata[15:0];
                bpc_pkg::REG_REF_TEMP:   r_cal.ref_temp_coeff    <= pwdata[15:0];
                bpc_pkg::REG_TEMP_SLOPE: r_cal.temp_slope_coeff  <= pwdata[15:0];
                default: ;  // unmapped word, write dropped
            endcase
        end
    end

    // read-back mux
    always_comb begin
        case (paddr[4:2])
            bpc_pkg::REG_SENS:       prdata = {16'h0000, r_cal.sens_coeff};
            bpc_pkg::REG_OFFSET:     prdata = {16'h0000, r_cal.offset_coeff};
            bpc_pkg::REG_SENS_TEMP:  prdata = {16'h0000, r_cal.sens_temp_coeff};
            bpc_pkg::REG_OFFSET_TMP: prdata = {16'h0000, r_cal.offset_temp_coeff};
            bpc_pkg::REG_REF_TEMP:   prdata = {16'h0000, r_cal.ref_temp_coeff};
            bpc_pkg::REG_TEMP_SLOPE: prdata = {16'h0000, r_cal.temp_slope_coeff};
            default:                 prdata = '0;
        endcase
    end

    logic signed [14:0] temperature;
    logic [16:0]        pressure;

    // datapath: dT, products, first-order terms, squares, second-order
    // terms, corrections, D1*SENS partials, subtract, shift and clamp
    bpc_pipe u_pipe (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cal             (r_cal),
        .i_in_valid        (i_s_axis_tvalid),
        .o_in_ready        (o_s_axis_tready),
        .i_raw_pressure    (i_s_axis_tdata[23:0]),
        .i_raw_temperature (i_s_axis_tdata[47:24]),
        .o_out_valid       (o_m_axis_tvalid),
        .i_out_ready       (i_m_axis_tready),
        .o_temperature     (temperature),
        .o_pressure        (pressure)
    );

    assign o_m_axis_tdata = {pressure, temperature};

endmodule

@@ rtl/core/bpc_checker.sv @@
// port-level checks on the pressure compensation block, bound to the top
// depends on assert_macros.svh, bpc_pkg and baro_pressure_compensation
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata
);

    localparam logic signed [14:0] TEMP_LO = 15'(bpc_pkg::TEMP_MIN);
    localparam logic signed [14:0] TEMP_HI = 15'(bpc_pkg::TEMP_MAX);
    localparam logic [16:0]        PRES_LO = 17'(bpc_pkg::PRES_MIN);
    localparam logic [16:0]        PRES_HI = 17'(bpc_pkg::PRES_MAX);

    logic               m_valid;
    logic [31:0]        m_data;
    logic               out_stall;
    logic signed [14:0] temp_out;
    logic [16:0]        pres_out;
    logic               temp_ok;
    logic               pres_ok;

    assign m_valid   = o_m_axis_tvalid;
    assign m_data    = o_m_axis_tdata;
    assign out_stall = o_m_axis_tvalid & ~i_m_axis_tready;
    assign temp_out  = o_m_axis_tdata[14:0];
    assign pres_out  = o_m_axis_tdata[31:15];
    assign temp_ok   = (temp_out >= TEMP_LO) && (temp_out <= TEMP_HI);
    assign pres_ok   = (pres_out >= PRES_LO) && (pres_out <= PRES_HI);

    // a stalled result holds its value
    `BPC_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> m_valid && $stable(m_data), "item not held")

    // temperature stays inside the clamp window
    `BPC_ASSERT(a_temp_range, i_clk, i_rst_n, m_valid |-> temp_ok, "temperature out of range")

    // pressure stays inside the clamp window
    `BPC_ASSERT(a_pres_range, i_clk, i_rst_n, m_valid |-> pres_ok, "pressure out of range")

    // reset empties the pipeline
    `BPC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_valid, "output valid right after reset")

endmodule

bind baro_pressure_compensation bpc_checker u_bpc_checker (.*);

@@ tb/sv/baro_pressure_compensation_tb.sv @@
// testbench for the barometric pressure compensation block: random and directed raw pairs,
// results checked in order against a built-in second-order compensation predictor
// depends on bpc_pkg and baro_pressure_compensation
`timescale 1ns / 1ps

module baro_pressure_compensation_tb;

    localparam int          NUM_CAL_REGS = 6;
    localparam logic [23:0] RAW_MAX      = 24'hFFFFFF;
    localparam logic [23:0] NOMINAL_D1   = 24'd6465444;
    localparam logic [23:0] NOMINAL_D2   = 24'd8077636;
    // byte addresses past the last calibration word
    localparam logic [4:0]  ADDR_UNUSED_LO = 5'd24;
    localparam logic [4:0]  ADDR_UNUSED_HI = 5'd28;
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          ITEMS_PER_PHASE = 130;

    // one compensated reading as it leaves the block
    typedef struct {
        logic signed [14:0] temp;
        logic [16:0]        pres;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;   // raw_pressure[23:0], raw_temperature[47:24]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b1;
    logic [31:0] o_m_axis_tdata;        // temperature[14:0], pressure[31:15]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // calibration words as the block should hold them
    bpc_pkg::t_cal cal_mirror = '0;
    t_reading      expected_readings[$];
    int            mismatches = 0;

    // source bursts and sink stall pattern
    bit source_gaps = 1'b0;
    bit sink_stalls = 1'b0;
    int burst_left = 0;
    int sink_run = 0;
    bit sink_state = 1'b1;

    baro_pressure_compensation uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // generous bound on the whole run
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // second-order compensation of one raw pair with the current calibration;
    // arithmetic shifts on signed 64-bit values floor toward minus infinity
    function automatic t_reading compensate(input logic [23:0] d1_raw,
                                            input logic [23:0] d2_raw);
        longint   d1, d2, c1, c2, c3, c4, c5, c6;
        longint   dt, temp, off, sens, t2, off2, sens2, a, b, p;
        t_reading r;
        d1 = d1_raw;
        d2 = d2_raw;
        c1 = cal_mirror.sens_coeff;
        c2 = cal_mirror.offset_coeff;
        c3 = cal_mirror.sens_temp_coeff;
        c4 = cal_mirror.offset_temp_coeff;
        c5 = cal_mirror.ref_temp_coeff;
        c6 = cal_mirror.temp_slope_coeff;
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        dt = d2 - c5 * 256;
        temp = bpc_pkg::TEMP_REF + ((dt * c6) >>> 23);
        off = c2 * 131072 + ((c4 * dt) >>> 6);
        sens = c1 * 65536 + ((c3 * dt) >>> 7);
        // thresholds look at the first-order temperature
        if (temp < bpc_pkg::TEMP_REF) begin
            a = temp - bpc_pkg::TEMP_REF;
            t2 = (dt * dt) >>> 31;
            off2 = (61 * a * a) >>> 4;
            sens2 = 2 * a * a;
            if (temp < bpc_pkg::TEMP_LOW) begin
                b = temp - bpc_pkg::TEMP_LOW;
                off2 += 15 * b * b;
                sens2 += 8 * b * b;
            end
        end
        temp -= t2;
        off -= off2;
        sens -= sens2;
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        if (temp < bpc_pkg::TEMP_MIN) temp = bpc_pkg::TEMP_MIN;
        if (temp > bpc_pkg::TEMP_MAX) temp = bpc_pkg::TEMP_MAX;
        if (p < bpc_pkg::PRES_MIN) p = bpc_pkg::PRES_MIN;
        if (p > bpc_pkg::PRES_MAX) p = bpc_pkg::PRES_MAX;
        r.temp = temp[14:0];
        r.pres = p[16:0];
        return r;
    endfunction

    function automatic logic [23:0] clamp_raw(input longint v);
        if (v < 0) return '0;
        if (v > RAW_MAX) return RAW_MAX;
        return v[23:0];
    endfunction

    // raw temperature whose first-order result lands exactly on target, unless c6 is zero or the raw value clamps
    function automatic logic [23:0] raw_temp_for(input int target);
        longint k, dt, c6;
        k = target - bpc_pkg::TEMP_REF;
        c6 = cal_mirror.temp_slope_coeff;
        if (c6 == 0)
            dt = 0;
        else if (k > 0)
            dt = (k * 8388608 + c6 - 1) / c6;
        else
            dt = (k * 8388608) / c6;
        return clamp_raw(longint'(cal_mirror.ref_temp_coeff) * 256 + dt);
    endfunction

    function automatic logic [4:0] reg_addr(input bpc_pkg::t_reg_idx idx);
        return {idx, 2'b00};
    endfunction

    function automatic logic [15:0] cal_word(input bpc_pkg::t_cal c,
                                             input bpc_pkg::t_reg_idx idx);
        case (idx)
            bpc_pkg::REG_SENS:       return c.sens_coeff;
            bpc_pkg::REG_OFFSET:     return c.offset_coeff;
            bpc_pkg::REG_SENS_TEMP:  return c.sens_temp_coeff;
            bpc_pkg::REG_OFFSET_TMP: return c.offset_temp_coeff;
            bpc_pkg::REG_REF_TEMP:   return c.ref_temp_coeff;
            bpc_pkg::REG_TEMP_SLOPE: return c.temp_slope_coeff;
            default:                 return '0;
        endcase
    endfunction

    task automatic apb_write(input logic [4:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // only the low half lands; unknown indexes are dropped
        case (addr[4:2])
            bpc_pkg::REG_SENS:       cal_mirror.sens_coeff        = data[15:0];
            bpc_pkg::REG_OFFSET:     cal_mirror.offset_coeff      = data[15:0];
            bpc_pkg::REG_SENS_TEMP:  cal_mirror.sens_temp_coeff   = data[15:0];
            bpc_pkg::REG_OFFSET_TMP: cal_mirror.offset_temp_coeff = data[15:0];
            bpc_pkg::REG_REF_TEMP:   cal_mirror.ref_temp_coeff    = data[15:0];
            bpc_pkg::REG_TEMP_SLOPE: cal_mirror.temp_slope_coeff  = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(input logic [4:0] addr, input logic [15:0] want);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {16'h0000, want})
            report_mismatch($sformatf("register at 0x%02h reads %h, expected %h",
                                      addr, prdata, want));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_calibration();
        for (int i = 0; i < NUM_CAL_REGS; i++)
            check_register(reg_addr(bpc_pkg::t_reg_idx'(i)),
                           cal_word(cal_mirror, bpc_pkg::t_reg_idx'(i)));
    endtask

    // upper data bits carry junk that the register must drop
    task automatic write_calibration(input bpc_pkg::t_cal c);
        for (int i = 0; i < NUM_CAL_REGS; i++)
            apb_write(reg_addr(bpc_pkg::t_reg_idx'(i)),
                      {16'($urandom), cal_word(c, bpc_pkg::t_reg_idx'(i))});
        check_calibration();
    endtask

    // one raw pair into the slave side, with a random gap between bursts when source gaps are on
    task automatic send_reading(input logic [23:0] d1, input logic [23:0] d2);
        if (burst_left == 0) begin
            if (source_gaps) begin
                repeat ($urandom_range(1, 6)) begin
                    @(negedge i_clk);
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {d2, d1};
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_readings.push_back(compensate(d1, d2));
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // most pairs sit near the reference temperature or on a chosen temperature,
    // the rest span the whole raw range
    task automatic send_random_reading();
        int          kind;
        logic [23:0] d1, d2;
        longint      centre;
        kind = $urandom_range(0, 9);
        d1 = 24'($urandom);
        centre = longint'(cal_mirror.ref_temp_coeff) * 256;
        if (kind < 4)
            d2 = clamp_raw(centre + longint'(int'($urandom_range(0, 1 << 23)) - (1 << 22)));
        else if (kind < 7)
            d2 = raw_temp_for(int'($urandom_range(0, 14000)) - 5000);
        else
            d2 = 24'($urandom);
        send_reading(d1, d2);
    endtask

    // registers at reset: everything still runs and the pressure saturates
    task automatic test_uncalibrated();
        check_calibration();
        send_reading('0, '0);
        send_reading(RAW_MAX, RAW_MAX);
        send_reading(RAW_MAX, '0);
        send_reading('0, RAW_MAX);
        wait_until_drained();
    endtask

    // nominal calibration, both temperature thresholds from each side and saturation
    task automatic test_datasheet_point();
        bpc_pkg::t_cal c;
        c.sens_coeff        = 16'd46372;
        c.offset_coeff      = 16'd43981;
        c.sens_temp_coeff   = 16'd29059;
        c.offset_temp_coeff = 16'd27842;
        c.ref_temp_coeff    = 16'd31553;
        c.temp_slope_coeff  = 16'd28165;
        write_calibration(c);
        send_reading(NOMINAL_D1, NOMINAL_D2);
        send_reading('0, raw_temp_for(bpc_pkg::TEMP_REF));
        send_reading(RAW_MAX, raw_temp_for(bpc_pkg::TEMP_REF - 1));
        send_reading(NOMINAL_D1, raw_temp_for(bpc_pkg::TEMP_LOW));
        send_reading(NOMINAL_D1, raw_temp_for(bpc_pkg::TEMP_LOW - 1));
        send_reading(NOMINAL_D1, raw_temp_for(bpc_pkg::TEMP_MIN - 1));
        send_reading(NOMINAL_D1, raw_temp_for(bpc_pkg::TEMP_MAX));
        send_reading(NOMINAL_D1, raw_temp_for(bpc_pkg::TEMP_MAX + 1));
        send_reading(24'hAAAAAA, 24'h555555);
        send_reading(24'h555555, 24'hAAAAAA);
        send_reading('0, '0);
        send_reading(RAW_MAX, RAW_MAX);
        wait_until_drained();
    endtask

    // every calibration word at full scale
    task automatic test_full_scale_calibration();
        write_calibration('1);
        send_reading('0, '0);
        send_reading(RAW_MAX, RAW_MAX);
        send_reading(RAW_MAX, '0);
        send_reading('0, RAW_MAX);
        send_reading(NOMINAL_D1, raw_temp_for(bpc_pkg::TEMP_LOW - 1));
        wait_until_drained();
    endtask

    // writes past the last word are dropped and those addresses read zero
    task automatic test_register_map();
        apb_write(ADDR_UNUSED_LO, $urandom);
        apb_write(ADDR_UNUSED_HI, $urandom);
        check_register(ADDR_UNUSED_LO, '0);
        check_register(ADDR_UNUSED_HI, '0);
        check_calibration();
        send_reading(NOMINAL_D1, NOMINAL_D2);
        wait_until_drained();
    endtask

    // random pairs under a series of calibrations, extremes among them
    task automatic test_random_calibrations();
        bpc_pkg::t_cal c;
        for (int phase = 0; phase < 7; phase++) begin
            c = bpc_pkg::t_cal'({$urandom, $urandom, $urandom});
            case (phase)
                1: c = '1;
                3: c = '0;
                4: begin
                    c.ref_temp_coeff   = '1;
                    c.temp_slope_coeff = '1;
                end
                5: begin
                    c.ref_temp_coeff   = '0;
                    c.temp_slope_coeff = '1;
                end
                default: ;
            endcase
            write_calibration(c);
            // first phase runs at full rate on both sides
            source_gaps = (phase != 0) && ($urandom_range(0, 3) != 0);
            sink_stalls = (phase != 0) && ($urandom_range(0, 3) != 0);
            repeat (ITEMS_PER_PHASE) send_random_reading();
            wait_until_drained();
        end
    endtask

    // sink: ready runs and stall runs of random length
    always @(negedge i_clk) begin
        if (!sink_stalls) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            if (sink_run == 0) begin
                sink_state = !sink_state;
                sink_run = sink_state ? $urandom_range(1, 12) : $urandom_range(1, 8);
            end
            sink_run--;
            i_m_axis_tready <= sink_state;
        end
    end

    // every accepted result against the oldest pending reading
    always @(posedge i_clk) begin : check_results
        t_reading want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch($sformatf("result %h with no item pending", o_m_axis_tdata));
            end else begin
                want = expected_readings.pop_front();
                if (o_m_axis_tdata[14:0] !== want.temp)
                    report_mismatch($sformatf("temperature %0d, expected %0d",
                                              $signed(o_m_axis_tdata[14:0]), want.temp));
                if (o_m_axis_tdata[31:15] !== want.pres)
                    report_mismatch($sformatf("pressure %0d, expected %0d",
                                              o_m_axis_tdata[31:15], want.pres));
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_uncalibrated();
        test_datasheet_point();
        test_full_scale_calibration();
        test_register_map();
        test_random_calibrations();

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_readings.size() != 0)
            report_mismatch("readings still pending at the end");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
